FILE: rtl/leased_retry_work_queue_macros.svh
// Assertion macros shared by the work queue RTL.
`ifndef LEASED_RETRY_WORK_QUEUE_MACROS_SVH
`define LEASED_RETRY_WORK_QUEUE_MACROS_SVH

// Same-cycle implication under asynchronous active-low reset.
`define LRWQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under asynchronous active-low reset.
`define LRWQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/lrwq_pkg.sv
// ----------------------------------------------------------------------------
// lrwq_pkg
// Types, codes and helpers of the leased retry work queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lrwq_pkg;

	localparam int CAPACITY  = 64;
	localparam int IDX_W     = $clog2(CAPACITY);
	localparam int CNT_W     = IDX_W + 1;
	localparam int TIME_W    = 48;
	localparam int KEY_W     = 32;
	localparam int REGION_W  = 16;
	localparam int ENTITY_W  = 64;
	localparam int PAYLOAD_W = 32;
	localparam int ATT_W     = 6;
	localparam int ORDER_W   = 32;
	localparam int LEASE_W   = 16;
	localparam int LIFE_W    = 22;
	localparam int OP_W      = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 22;

	// operation codes
	localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
	localparam logic [OP_W-1:0] OP_LEASE   = 3'd1;
	localparam logic [OP_W-1:0] OP_ACK     = 3'd2;
	localparam logic [OP_W-1:0] OP_NACK    = 3'd3;
	localparam logic [OP_W-1:0] OP_FIND    = 3'd4;
	localparam logic [OP_W-1:0] OP_PURGE   = 3'd5;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ATTEMPTS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEASE_DUR    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LIFETIME     = 2'd2;

	// register limits and reset values
	localparam logic [ATT_W-1:0]   ATT_MIN   = 6'd1;
	localparam logic [ATT_W-1:0]   ATT_MAX   = 6'd32;
	localparam logic [ATT_W-1:0]   ATT_RST   = 6'd3;
	localparam logic [LEASE_W-1:0] LEASE_MIN = 16'd100;
	localparam logic [LEASE_W-1:0] LEASE_MAX = 16'd60000;
	localparam logic [LEASE_W-1:0] LEASE_RST = 16'd5000;
	localparam logic [LIFE_W-1:0]  LIFE_MIN  = 22'd1000;
	localparam logic [LIFE_W-1:0]  LIFE_MAX  = 22'd3600000;
	localparam logic [LIFE_W-1:0]  LIFE_RST  = 22'd60000;

	typedef struct packed {
		logic [KEY_W-1:0]     key;
		logic [REGION_W-1:0]  region;
		logic [ENTITY_W-1:0]  entity;
		logic [PAYLOAD_W-1:0] payload;
		logic [TIME_W-1:0]    created;
		logic [TIME_W-1:0]    expires;
		logic [TIME_W-1:0]    lease_until;
		logic [ATT_W-1:0]     attempts;
		logic [ORDER_W-1:0]   order;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// time plus duration, saturating at the top of the time range
	function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] a,
			input logic [LIFE_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + (TIME_W+1)'(b);
		return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/lrwq_ram.sv
// ----------------------------------------------------------------------------
// lrwq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lrwq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/leased_retry_work_queue.sv
// ----------------------------------------------------------------------------
// leased_retry_work_queue
// Bounded work queue with leases, retries and expiry, held in one entry RAM.
// ----------------------------------------------------------------------------
// Every request sweeps all CAPACITY slots through the entry RAM, one read a cycle,
// then drains the read pipeline and writes back from the finish state, which
// waits while the last result is still held. One request at a time: a new one
// is taken only in the idle state. Reset empties the queue at once through
// per-slot valid flip-flops and restores the register defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "leased_retry_work_queue_macros.svh"
module leased_retry_work_queue (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration
	input  wire logic                                 cfg_wr_en,
	input  wire logic [lrwq_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [lrwq_pkg::CFG_DATA_W-1:0]      cfg_data,
	// request channel
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [lrwq_pkg::OP_W-1:0]            op,
	input  wire logic [lrwq_pkg::TIME_W-1:0]          now_ms,
	input  wire logic [lrwq_pkg::KEY_W-1:0]           action_key,
	input  wire logic [lrwq_pkg::REGION_W-1:0]        region_key,
	input  wire logic [lrwq_pkg::ENTITY_W-1:0]        entity_ref,
	input  wire logic [lrwq_pkg::PAYLOAD_W-1:0]       payload_ref,
	input  wire logic [lrwq_pkg::TIME_W-1:0]          created_ms,
	input  wire logic [lrwq_pkg::TIME_W-1:0]          expires_ms,
	input  wire logic signed [lrwq_pkg::TIME_W-1:0]   retry_at_ms,
	// result channel
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic                                      ok,
	output logic [lrwq_pkg::KEY_W-1:0]                out_action_key,
	output logic [lrwq_pkg::REGION_W-1:0]             out_region_key,
	output logic [lrwq_pkg::ENTITY_W-1:0]             out_entity_ref,
	output logic [lrwq_pkg::PAYLOAD_W-1:0]            out_payload_ref,
	output logic [lrwq_pkg::TIME_W-1:0]               out_created_ms,
	output logic [lrwq_pkg::TIME_W-1:0]               out_expires_ms,
	output logic [lrwq_pkg::TIME_W-1:0]               out_lease_until_ms,
	output logic [lrwq_pkg::ATT_W-1:0]                out_attempts,
	output logic [lrwq_pkg::CNT_W-1:0]                occupancy,
	output logic [lrwq_pkg::CNT_W-1:0]                removed_count
);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

	state_t state_q;

	// configuration registers
	logic [lrwq_pkg::ATT_W-1:0]   max_att_q;
	logic [lrwq_pkg::LEASE_W-1:0] lease_dur_q;
	logic [lrwq_pkg::LIFE_W-1:0]  life_q;

	// request held for the sweep
	logic [lrwq_pkg::OP_W-1:0]       op_q;
	logic [lrwq_pkg::TIME_W-1:0]     now_q;
	logic [lrwq_pkg::KEY_W-1:0]      key_q;
	logic [lrwq_pkg::REGION_W-1:0]   region_q;
	logic [lrwq_pkg::ENTITY_W-1:0]   entity_q;
	logic [lrwq_pkg::PAYLOAD_W-1:0]  payload_q;
	logic [lrwq_pkg::TIME_W-1:0]     created_q;
	logic [lrwq_pkg::TIME_W-1:0]     expires_q;
	logic [lrwq_pkg::TIME_W-1:0]     retry_q;

	// queue state
	logic [lrwq_pkg::CAPACITY-1:0] valid_q;
	logic [lrwq_pkg::CNT_W-1:0]    count_q;
	logic [lrwq_pkg::ORDER_W-1:0]  next_order_q;

	// sweep
	logic [lrwq_pkg::CNT_W-1:0]    addr_q;
	logic                          rd_s1;
	logic [lrwq_pkg::IDX_W-1:0]    idx_s1;
	logic                          hit_q;
	logic [lrwq_pkg::IDX_W-1:0]    hit_idx_q;
	logic [lrwq_pkg::ORDER_W-1:0]  best_age_q;
	lrwq_pkg::entry_t              best_q;
	logic [lrwq_pkg::CNT_W-1:0]    removed_q;

	// result register
	logic                          out_valid_q;
	logic                          ok_q;
	lrwq_pkg::entry_t              out_entry_q;
	logic [lrwq_pkg::CNT_W-1:0]    occ_q;
	logic [lrwq_pkg::CNT_W-1:0]    rem_q;

	// RAM
	logic                                ram_we;
	logic [lrwq_pkg::IDX_W-1:0]          ram_waddr;
	lrwq_pkg::entry_t                    ram_wentry;
	logic                                ram_re;
	logic [lrwq_pkg::ENTRY_W-1:0]        ram_rdata;

	lrwq_ram #(
		.WIDTH (lrwq_pkg::ENTRY_W),
		.DEPTH (lrwq_pkg::CAPACITY)
	) u_entries (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wentry),
		.re    (ram_re),
		.raddr (addr_q[lrwq_pkg::IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// examine the slot read last cycle
	lrwq_pkg::entry_t             rd_entry;
	logic                         slot_live;
	logic [lrwq_pkg::ORDER_W-1:0] age;
	logic                         older;
	logic                         expired;
	logic                         exhausted;
	logic                         take;
	logic                         drop;

	always_comb begin
		rd_entry  = lrwq_pkg::entry_t'(ram_rdata);
		slot_live = rd_s1 && valid_q[idx_s1];
		age       = next_order_q - rd_entry.order;
		older     = !hit_q || (age > best_age_q);
		expired   = rd_entry.expires <= now_q;
		exhausted = (rd_entry.attempts >= max_att_q) && (rd_entry.lease_until <= now_q);
		take      = 1'b0;
		drop      = 1'b0;
		case (op_q)
			lrwq_pkg::OP_ENQUEUE: begin
				take = rd_s1 && !valid_q[idx_s1] && !hit_q;
			end
			lrwq_pkg::OP_LEASE: begin
				drop = slot_live && (expired || exhausted);
				take = slot_live && !expired && !exhausted && older
					&& (rd_entry.region == region_q)
					&& (rd_entry.lease_until <= now_q)
					&& (rd_entry.attempts < max_att_q);
			end
			lrwq_pkg::OP_ACK, lrwq_pkg::OP_NACK, lrwq_pkg::OP_FIND: begin
				take = slot_live && (rd_entry.key == key_q) && older;
			end
			lrwq_pkg::OP_PURGE: begin
				drop = slot_live && expired;
			end
			default: begin
				take = 1'b0;
			end
		endcase
	end

	// finish: work out the write-back and the result
	logic                         fin_go;
	logic                         fin_ok;
	logic                         fin_emit;
	logic                         fin_set;
	logic                         fin_clr;
	logic [lrwq_pkg::TIME_W-1:0]  enq_created;
	logic [lrwq_pkg::TIME_W-1:0]  enq_expires;
	lrwq_pkg::entry_t             emit_entry;

	always_comb begin
		fin_go      = (state_q == ST_FINISH) && (!out_valid_q || out_ready);
		fin_ok      = 1'b0;
		fin_emit    = 1'b0;
		fin_set     = 1'b0;
		fin_clr     = 1'b0;
		ram_we      = 1'b0;
		ram_waddr   = hit_idx_q;
		ram_wentry  = best_q;
		emit_entry  = best_q;
		enq_created = (created_q == '0) ? now_q : created_q;
		enq_expires = (expires_q <= enq_created) ? lrwq_pkg::add_sat(enq_created, life_q)
			: expires_q;
		case (op_q)
			lrwq_pkg::OP_ENQUEUE: begin
				if (hit_q && entity_q != '0 && region_q != '0
						&& count_q < lrwq_pkg::CNT_W'(lrwq_pkg::CAPACITY)) begin
					fin_ok                 = 1'b1;
					fin_set                = 1'b1;
					ram_we                 = fin_go;
					ram_wentry.key         = key_q;
					ram_wentry.region      = region_q;
					ram_wentry.entity      = entity_q;
					ram_wentry.payload     = payload_q;
					ram_wentry.created     = enq_created;
					ram_wentry.expires     = enq_expires;
					ram_wentry.lease_until = '0;
					ram_wentry.attempts    = '0;
					ram_wentry.order       = next_order_q;
				end
			end
			lrwq_pkg::OP_LEASE: begin
				if (hit_q) begin
					fin_ok                 = 1'b1;
					fin_emit               = 1'b1;
					ram_we                 = fin_go;
					ram_wentry.attempts    = best_q.attempts + 1'b1;
					ram_wentry.lease_until = lrwq_pkg::add_sat(now_q,
						lrwq_pkg::LIFE_W'(lease_dur_q));
					emit_entry             = ram_wentry;
				end
			end
			lrwq_pkg::OP_ACK: begin
				fin_ok  = hit_q;
				fin_clr = hit_q;
			end
			lrwq_pkg::OP_NACK: begin
				if (hit_q) begin
					fin_ok = 1'b1;
					if (best_q.attempts >= max_att_q) begin
						fin_clr = 1'b1;
					end else begin
						ram_we                 = fin_go;
						ram_wentry.lease_until = retry_q[lrwq_pkg::TIME_W-1] ? '0 : retry_q;
					end
				end
			end
			lrwq_pkg::OP_FIND: begin
				fin_ok   = hit_q;
				fin_emit = hit_q;
			end
			default: begin
				fin_ok = 1'b0;
			end
		endcase
	end

	assign ram_re   = (state_q == ST_SCAN) && (addr_q < lrwq_pkg::CNT_W'(lrwq_pkg::CAPACITY));
	assign in_ready = (state_q == ST_IDLE);

	// state, sweep, queue state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			max_att_q    <= lrwq_pkg::ATT_RST;
			lease_dur_q  <= lrwq_pkg::LEASE_RST;
			life_q       <= lrwq_pkg::LIFE_RST;
			valid_q      <= '0;
			count_q      <= '0;
			next_order_q <= '0;
			addr_q       <= '0;
			rd_s1        <= 1'b0;
			hit_q        <= 1'b0;
			removed_q    <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// configuration writes, clamped into range
			if (cfg_wr_en) begin
				case (cfg_index)
					lrwq_pkg::REG_MAX_ATTEMPTS: begin
						max_att_q <= (cfg_data[5:0] < lrwq_pkg::ATT_MIN) ? lrwq_pkg::ATT_MIN
							: (cfg_data[5:0] > lrwq_pkg::ATT_MAX) ? lrwq_pkg::ATT_MAX
							: cfg_data[5:0];
					end
					lrwq_pkg::REG_LEASE_DUR: begin
						lease_dur_q <= (cfg_data[15:0] < lrwq_pkg::LEASE_MIN) ? lrwq_pkg::LEASE_MIN
							: (cfg_data[15:0] > lrwq_pkg::LEASE_MAX) ? lrwq_pkg::LEASE_MAX
							: cfg_data[15:0];
					end
					lrwq_pkg::REG_LIFETIME: begin
						life_q <= (cfg_data < lrwq_pkg::LIFE_MIN) ? lrwq_pkg::LIFE_MIN
							: (cfg_data > lrwq_pkg::LIFE_MAX) ? lrwq_pkg::LIFE_MAX
							: cfg_data;
					end
					default: begin
						life_q <= life_q;
					end
				endcase
			end

			// release the result once taken, unless a new one replaces it
			if (out_valid_q && out_ready && !fin_go) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q   <= ST_SCAN;
						addr_q    <= '0;
						rd_s1     <= 1'b0;
						hit_q     <= 1'b0;
						removed_q <= '0;
					end
				end
				ST_SCAN: begin
					// advance the read address, track the best slot, drop stale slots
					rd_s1 <= ram_re;
					if (ram_re) begin
						addr_q <= addr_q + 1'b1;
					end
					if (take) begin
						hit_q      <= 1'b1;
						hit_idx_q  <= idx_s1;
						best_age_q <= age;
						best_q     <= rd_entry;
					end
					if (drop) begin
						valid_q[idx_s1] <= 1'b0;
						count_q         <= count_q - 1'b1;
						removed_q       <= removed_q + 1'b1;
					end
					if (!ram_re && !rd_s1) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (fin_go) begin
						if (fin_set) begin
							valid_q[hit_idx_q] <= 1'b1;
							count_q            <= count_q + 1'b1;
							next_order_q       <= next_order_q + 1'b1;
						end
						if (fin_clr) begin
							valid_q[hit_idx_q] <= 1'b0;
							count_q            <= count_q - 1'b1;
						end
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers: request capture, read pipeline, result
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q      <= op;
			now_q     <= now_ms;
			key_q     <= action_key;
			region_q  <= region_key;
			entity_q  <= entity_ref;
			payload_q <= payload_ref;
			created_q <= created_ms;
			expires_q <= expires_ms;
			retry_q   <= retry_at_ms;
		end
		idx_s1 <= addr_q[lrwq_pkg::IDX_W-1:0];
		if (fin_go) begin
			ok_q        <= fin_ok;
			out_entry_q <= fin_emit ? emit_entry : '0;
			occ_q       <= fin_set ? count_q + 1'b1 : (fin_clr ? count_q - 1'b1 : count_q);
			rem_q       <= (op_q == lrwq_pkg::OP_PURGE) ? removed_q : '0;
		end
	end

	assign out_valid          = out_valid_q;
	assign ok                 = ok_q;
	assign out_action_key     = out_entry_q.key;
	assign out_region_key     = out_entry_q.region;
	assign out_entity_ref     = out_entry_q.entity;
	assign out_payload_ref    = out_entry_q.payload;
	assign out_created_ms     = out_entry_q.created;
	assign out_expires_ms     = out_entry_q.expires;
	assign out_lease_until_ms = out_entry_q.lease_until;
	assign out_attempts       = out_entry_q.attempts;
	assign occupancy          = occ_q;
	assign removed_count      = rem_q;

	// checks
	`LRWQ_ASSERT_NOW(a_count_matches, clk, arst_n, 1'b1, $countones(valid_q) == count_q, "entry count disagrees with valid slots")
	`LRWQ_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= lrwq_pkg::CNT_W'(lrwq_pkg::CAPACITY), "entry count above capacity")
	`LRWQ_ASSERT_NEXT(a_accept_scans, clk, arst_n, in_valid && in_ready, state_q == ST_SCAN, "accepted request did not start a sweep")
	`LRWQ_ASSERT_NEXT(a_finish_waits, clk, arst_n, state_q == ST_FINISH && out_valid_q && !out_ready, state_q == ST_FINISH && out_valid_q, "result overwritten while still held")

endmodule
`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the leased retry work queue. A directed table covers
// the rejects, saturating times, leases, nacks and purges. Random requests
// follow under three register settings and three idling patterns. Results are
// checked against an in-bench model; typed table rows set ok and occupancy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
	import lrwq_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 80;
	localparam int RANDOM_PER_PHASE = 500;

	typedef struct {
		logic [OP_W-1:0]      op;
		logic [TIME_W-1:0]    now;
		logic [KEY_W-1:0]     key;
		logic [REGION_W-1:0]  region;
		logic [ENTITY_W-1:0]  entity;
		logic [PAYLOAD_W-1:0] payload;
		logic [TIME_W-1:0]    created;
		logic [TIME_W-1:0]    expires;
		logic [TIME_W-1:0]    retry;
	} request_t;

	typedef struct {
		logic                 ok;
		logic [KEY_W-1:0]     key;
		logic [REGION_W-1:0]  region;
		logic [ENTITY_W-1:0]  entity;
		logic [PAYLOAD_W-1:0] payload;
		logic [TIME_W-1:0]    created;
		logic [TIME_W-1:0]    expires;
		logic [TIME_W-1:0]    lease_until;
		logic [ATT_W-1:0]     attempts;
		logic [CNT_W-1:0]     occ;
		logic [CNT_W-1:0]     removed;
	} outcome_t;

	typedef struct {
		request_t   req;
		logic       typed;
		logic       t_ok;
		logic [CNT_W-1:0] t_occ;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [OP_W-1:0] op = '0;
	logic [TIME_W-1:0] now_ms = '0;
	logic [KEY_W-1:0] action_key = '0;
	logic [REGION_W-1:0] region_key = '0;
	logic [ENTITY_W-1:0] entity_ref = '0;
	logic [PAYLOAD_W-1:0] payload_ref = '0;
	logic [TIME_W-1:0] created_ms = '0;
	logic [TIME_W-1:0] expires_ms = '0;
	logic signed [TIME_W-1:0] retry_at_ms = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic ok;
	logic [KEY_W-1:0] out_action_key;
	logic [REGION_W-1:0] out_region_key;
	logic [ENTITY_W-1:0] out_entity_ref;
	logic [PAYLOAD_W-1:0] out_payload_ref;
	logic [TIME_W-1:0] out_created_ms;
	logic [TIME_W-1:0] out_expires_ms;
	logic [TIME_W-1:0] out_lease_until_ms;
	logic [ATT_W-1:0] out_attempts;
	logic [CNT_W-1:0] occupancy;
	logic [CNT_W-1:0] removed_count;

	leased_retry_work_queue DUT (.*);

	// queue model state and registers
	logic              q_valid [CAPACITY];
	logic [KEY_W-1:0]  q_key [CAPACITY];
	logic [REGION_W-1:0] q_region [CAPACITY];
	logic [ENTITY_W-1:0] q_entity [CAPACITY];
	logic [PAYLOAD_W-1:0] q_payload [CAPACITY];
	logic [TIME_W-1:0] q_created [CAPACITY];
	logic [TIME_W-1:0] q_expires [CAPACITY];
	logic [TIME_W-1:0] q_lease [CAPACITY];
	logic [ATT_W-1:0]  q_attempts [CAPACITY];
	logic [ORDER_W-1:0] q_order [CAPACITY];
	logic [ORDER_W-1:0] order_next = '0;
	int                held = 0;
	logic [ATT_W-1:0]  attempt_limit = ATT_RST;
	logic [TIME_W-1:0] lease_len = TIME_W'(LEASE_RST);
	logic [TIME_W-1:0] lifetime = TIME_W'(LIFE_RST);

	outcome_t pending_q [$];
	int fail_count = 0;
	int cycles = 0;
	int send_idle = 26;
	int recv_idle = 50;
	logic [TIME_W-1:0] clock_ms = '0;
	row_t dir_rows [$];

	// clock and reset
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// stall the result side
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_idle);

	function automatic logic [TIME_W-1:0] sat_add(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
		logic [TIME_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TIME_W] ? '1 : s[TIME_W-1:0];
	endfunction

	function automatic logic [ORDER_W-1:0] age(int i);
		return order_next - q_order[i];
	endfunction

	function automatic int oldest_with_key(logic [KEY_W-1:0] k);
		int best;
		best = -1;
		for (int i = 0; i < CAPACITY; i++)
			if (q_valid[i] && q_key[i] == k && (best < 0 || age(i) > age(best)))
				best = i;
		return best;
	endfunction

	function automatic void drop(int i);
		q_valid[i] = 1'b0;
		if (held > 0)
			held--;
	endfunction

	function automatic void report_entry(ref outcome_t o, input int i);
		o.key = q_key[i];
		o.region = q_region[i];
		o.entity = q_entity[i];
		o.payload = q_payload[i];
		o.created = q_created[i];
		o.expires = q_expires[i];
		o.lease_until = q_lease[i];
		o.attempts = q_attempts[i];
	endfunction

	// advance the queue model by one request
	function automatic outcome_t apply_request(request_t r);
		outcome_t o;
		int hit;
		int slot;
		int purged;
		logic [TIME_W-1:0] cr;
		logic [TIME_W-1:0] ex;
		o = '{default: '0};
		hit = -1;
		purged = 0;
		case (r.op)
			OP_ENQUEUE: begin
				if (r.entity != 0 && r.region != 0 && held < CAPACITY) begin
					slot = -1;
					for (int i = CAPACITY - 1; i >= 0; i--)
						if (!q_valid[i])
							slot = i;
					if (slot >= 0) begin
						cr = (r.created == 0) ? r.now : r.created;
						ex = (r.expires <= cr) ? sat_add(cr, lifetime) : r.expires;
						q_valid[slot] = 1'b1;
						q_key[slot] = r.key;
						q_region[slot] = r.region;
						q_entity[slot] = r.entity;
						q_payload[slot] = r.payload;
						q_created[slot] = cr;
						q_expires[slot] = ex;
						q_lease[slot] = '0;
						q_attempts[slot] = '0;
						q_order[slot] = order_next;
						order_next++;
						held++;
						o.ok = 1'b1;
					end
				end
			end
			OP_LEASE: begin
				for (int i = 0; i < CAPACITY; i++)
					if (q_valid[i] && (q_expires[i] <= r.now ||
							(q_attempts[i] >= attempt_limit && q_lease[i] <= r.now)))
						drop(i);
				for (int i = 0; i < CAPACITY; i++)
					if (q_valid[i] && q_region[i] == r.region && q_lease[i] <= r.now &&
							q_attempts[i] < attempt_limit && (hit < 0 || age(i) > age(hit)))
						hit = i;
				if (hit >= 0) begin
					q_attempts[hit]++;
					q_lease[hit] = sat_add(r.now, lease_len);
					o.ok = 1'b1;
					report_entry(o, hit);
				end
			end
			OP_ACK: begin
				hit = oldest_with_key(r.key);
				if (hit >= 0) begin
					drop(hit);
					o.ok = 1'b1;
				end
			end
			OP_NACK: begin
				hit = oldest_with_key(r.key);
				if (hit >= 0) begin
					if (q_attempts[hit] >= attempt_limit)
						drop(hit);
					else
						q_lease[hit] = r.retry[TIME_W-1] ? '0 : r.retry;
					o.ok = 1'b1;
				end
			end
			OP_FIND: begin
				hit = oldest_with_key(r.key);
				if (hit >= 0) begin
					o.ok = 1'b1;
					report_entry(o, hit);
				end
			end
			OP_PURGE: begin
				for (int i = 0; i < CAPACITY; i++)
					if (q_valid[i] && q_expires[i] <= r.now) begin
						drop(i);
						purged++;
					end
				o.removed = CNT_W'(purged);
			end
			default: ;
		endcase
		o.occ = CNT_W'(held);
		return o;
	endfunction

	// hold the request until it is taken, then log its expected result
	task automatic send_request(request_t r, logic typed, logic t_ok, logic [CNT_W-1:0] t_occ);
		outcome_t o;
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= r.op;
		now_ms <= r.now;
		action_key <= r.key;
		region_key <= r.region;
		entity_ref <= r.entity;
		payload_ref <= r.payload;
		created_ms <= r.created;
		expires_ms <= r.expires;
		retry_at_ms <= r.retry;
		do @(posedge clk); while (!in_ready);
		o = apply_request(r);
		if (typed) begin
			o.ok = t_ok;
			o.occ = t_occ;
		end
		pending_q = {pending_q, o};
	endtask

	// drain, let the block settle, then write all three registers
	task automatic program_regs(logic [CFG_DATA_W-1:0] att, logic [CFG_DATA_W-1:0] lease,
			logic [CFG_DATA_W-1:0] life);
		logic [TIME_W-1:0] v;
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_MAX_ATTEMPTS;
		cfg_data <= att;
		@(posedge clk);
		cfg_index <= REG_LEASE_DUR;
		cfg_data <= lease;
		@(posedge clk);
		cfg_index <= REG_LIFETIME;
		cfg_data <= life;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		v = TIME_W'(att[ATT_W-1:0]);
		attempt_limit = (v < ATT_MIN) ? ATT_MIN : (v > ATT_MAX) ? ATT_MAX : ATT_W'(v);
		v = TIME_W'(lease[LEASE_W-1:0]);
		lease_len = (v < LEASE_MIN) ? TIME_W'(LEASE_MIN) : (v > LEASE_MAX) ? TIME_W'(LEASE_MAX) : v;
		v = TIME_W'(life);
		lifetime = (v < LIFE_MIN) ? TIME_W'(LIFE_MIN) : (v > LIFE_MAX) ? TIME_W'(LIFE_MAX) : v;
	endtask

	function automatic logic [TIME_W-1:0] rand48();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[TIME_W-1:0];
	endfunction

	// mostly well-formed traffic on a few keys and regions, with some noise
	function automatic request_t random_request();
		request_t r;
		int pick;
		pick = $urandom_range(99);
		r.op = (pick < 35) ? OP_ENQUEUE : (pick < 55) ? OP_LEASE : (pick < 65) ? OP_ACK :
			(pick < 77) ? OP_NACK : (pick < 89) ? OP_FIND : (pick < 95) ? OP_PURGE :
			(pick < 97) ? OP_SPARE_6 : OP_SPARE_7;
		if ($urandom_range(99) < 96) begin
			clock_ms = clock_ms + TIME_W'($urandom_range(0, 2000));
			r.now = clock_ms;
		end else
			r.now = rand48();
		r.key = ($urandom_range(99) < 80) ? KEY_W'($urandom_range(0, 15)) : $urandom;
		pick = $urandom_range(99);
		r.region = (pick < 85) ? REGION_W'($urandom_range(1, 4)) : (pick < 90) ? '0 :
			REGION_W'($urandom);
		pick = $urandom_range(99);
		r.entity = (pick < 90) ? {$urandom, $urandom} : (pick < 95) ? '0 : '1;
		r.payload = $urandom;
		pick = $urandom_range(99);
		r.created = (pick < 50) ? '0 :
			(pick < 85) ? r.now - ((r.now > 500) ? TIME_W'($urandom_range(0, 500)) : '0) :
			rand48();
		pick = $urandom_range(99);
		r.expires = (pick < 40) ? '0 :
			(pick < 80) ? sat_add((r.created == 0) ? r.now : r.created,
				TIME_W'($urandom_range(1, 20000))) : rand48();
		pick = $urandom_range(99);
		r.retry = (pick < 40) ? sat_add(r.now, TIME_W'($urandom_range(0, 5000))) :
			(pick < 60) ? (rand48() | {1'b1, {TIME_W-1{1'b0}}}) : rand48();
		return r;
	endfunction

	function automatic row_t mk(logic [OP_W-1:0] o, logic [TIME_W-1:0] n, logic [KEY_W-1:0] k,
			logic [REGION_W-1:0] g, logic [ENTITY_W-1:0] e, logic [PAYLOAD_W-1:0] p,
			logic [TIME_W-1:0] c, logic [TIME_W-1:0] x, logic [TIME_W-1:0] rt,
			logic ty, logic tok, logic [CNT_W-1:0] tocc);
		row_t w;
		w.req = '{o, n, k, g, e, p, c, x, rt};
		w.typed = ty;
		w.t_ok = tok;
		w.t_occ = tocc;
		return w;
	endfunction

	// compare one result field
	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// check each result against the oldest expectation
	always @(posedge clk) begin : result_check
		outcome_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				$display("%0t: result expected none actual ok=%0b occupancy=%0d",
					$time, ok, occupancy);
				fail_count++;
			end else begin
				e = pending_q.pop_front();
				check_field("ok", e.ok, ok);
				check_field("out_action_key", e.key, out_action_key);
				check_field("out_region_key", e.region, out_region_key);
				check_field("out_entity_ref", e.entity, out_entity_ref);
				check_field("out_payload_ref", e.payload, out_payload_ref);
				check_field("out_created_ms", e.created, out_created_ms);
				check_field("out_expires_ms", e.expires, out_expires_ms);
				check_field("out_lease_until_ms", e.lease_until, out_lease_until_ms);
				check_field("out_attempts", e.attempts, out_attempts);
				check_field("occupancy", e.occ, occupancy);
				check_field("removed_count", e.removed, removed_count);
			end
		end
	end

	initial begin : stimulus
		localparam logic [TIME_W-1:0] T_MAX = '1;
		for (int i = 0; i < CAPACITY; i++)
			q_valid[i] = 1'b0;
		// directed table: rejects, saturation, leases, nacks, unknown ids, purge
		dir_rows = {dir_rows, mk(OP_FIND, 0, 5, 0, 0, 0, 0, 0, 0, 1, 0, 0)};
		dir_rows = {dir_rows, mk(OP_ENQUEUE, 0, 1, 1, 0, 1, 0, 0, 0, 1, 0, 0)};
		dir_rows = {dir_rows, mk(OP_ENQUEUE, 0, 1, 0, 1, 1, 0, 0, 0, 1, 0, 0)};
		dir_rows = {dir_rows, mk(OP_ENQUEUE, 1000, 5, 1, '1, '1, 0, 0, 0, 1, 1, 1)};
		dir_rows = {dir_rows, mk(OP_ENQUEUE, 2000, 5, 1, 2, 9, T_MAX, 0, 0, 1, 1, 2)};
		dir_rows = {dir_rows, mk(OP_ENQUEUE, 0, 7, '1, 3, 4, 100, 200, 0, 1, 1, 3)};
		dir_rows = {dir_rows, mk(OP_FIND, 500, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
		dir_rows = {dir_rows, mk(OP_LEASE, 1000, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0)};
		dir_rows = {dir_rows, mk(OP_LEASE, 1000, 0, 0, 0, 0, 0, 0, 0, 1, 0, 2)};
		dir_rows = {dir_rows, mk(OP_NACK, 1200, 5, 0, 0, 0, 0, 0, T_MAX, 0, 0, 0)};
		dir_rows = {dir_rows, mk(OP_NACK, 1300, 5, 0, 0, 0, 0, 0, T_MAX >> 1, 0, 0, 0)};
		dir_rows = {dir_rows, mk(OP_FIND, 1400, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
		dir_rows = {dir_rows, mk(OP_ACK, 1500, 5, 0, 0, 0, 0, 0, 0, 1, 1, 1)};
		dir_rows = {dir_rows, mk(OP_ACK, 1500, 99, 0, 0, 0, 0, 0, 0, 1, 0, 1)};
		dir_rows = {dir_rows, mk(OP_NACK, 1500, 99, 0, 0, 0, 0, 0, 0, 1, 0, 1)};
		dir_rows = {dir_rows, mk(OP_SPARE_6, T_MAX, 5, 1, 1, 1, 1, 1, 1, 1, 0, 1)};
		dir_rows = {dir_rows, mk(OP_SPARE_7, T_MAX, 5, 1, 1, 1, 1, 1, 1, 1, 0, 1)};
		dir_rows = {dir_rows, mk(OP_LEASE, T_MAX, 0, 1, 0, 0, 0, 0, 0, 1, 0, 0)};
		dir_rows = {dir_rows, mk(OP_ENQUEUE, T_MAX, 1, 2, 5, 6, 0, 0, 0, 1, 1, 1)};
		dir_rows = {dir_rows, mk(OP_PURGE, T_MAX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)};
		dir_rows = {dir_rows, mk(OP_ENQUEUE, 0, '1, 1, 1, 0, 0, T_MAX, 0, 1, 1, 1)};
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		foreach (dir_rows[i])
			send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].t_ok, dir_rows[i].t_occ);
		// below-range values clamp to the minimum
		program_regs(0, 50, 0);
		for (int n = 0; n < RANDOM_PER_PHASE; n++)
			send_request(random_request(), 1'b0, 1'b0, '0);
		// swap idling, above-range values clamp to the maximum
		send_idle = 50;
		recv_idle = 26;
		program_regs(63, 65535, '1);
		for (int n = 0; n < RANDOM_PER_PHASE; n++)
			send_request(random_request(), 1'b0, 1'b0, '0);
		// no idling, mid-range settings
		send_idle = 0;
		recv_idle = 0;
		program_regs(4, 2500, 30000);
		for (int n = 0; n < RANDOM_PER_PHASE; n++)
			send_request(random_request(), 1'b0, 1'b0, '0);
		in_valid <= 1'b0;
		while (pending_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/lrwq_pkg.sv
rtl/lrwq_ram.sv
rtl/leased_retry_work_queue.sv
tb/testbench.sv
